// ===== rtl/gba_pkg.sv =====
// shared types, constants and helpers for the grouped bitmap allocator
package gba_pkg;

  localparam int unsigned DEF_ENTRIES    = 4096;
  localparam int unsigned DEF_MAX_GROUPS = 8;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned BLK_W   = 13;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX       = '1;
  localparam logic [CFG_W-1:0] RST_TOTAL     = 13'd4096;
  localparam logic [CFG_W-1:0] RST_PER_GROUP = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PER_GROUP = 1'd1;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic accept;
    logic clear;
    logic fetch;
    logic check;
    logic scan;
    logic group;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic bad;
    logic alloc;
    logic query;
    logic bit_set;
    logic hit;
    logic miss;
    logic group_done;
  } status_t;

  // lowest set bit of a word
  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/grouped_bitmap_allocator.sv =====
// grouped first-fit bitmap allocator: top level joining controller and datapath
// sequence: range error and request type 3 go from fetch to the strobe; query and a free
// of a free block read the bitmap word and check it; a free then steps the group search and
// writes back; allocate scans the used words at one word per cycle, then group search and write
// throughput: one request at a time, start taken again the cycle after the strobe
// reset: a clearing pass zeroes every bitmap word, busy stays high
module grouped_bitmap_allocator #(
  parameter int unsigned ENTRIES    = gba_pkg::DEF_ENTRIES,
  parameter int unsigned MAX_GROUPS = gba_pkg::DEF_MAX_GROUPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gba_pkg::REQ_W-1:0]     in_req_type,
  input  logic [gba_pkg::IDX_W-1:0]     in_block_index,
  input  logic                          cfg_we,
  input  logic [gba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gba_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [gba_pkg::IDX_W-1:0]     out_result_index,
  output logic                          out_found,
  output logic                          out_is_used,
  output logic [gba_pkg::CNT_W-1:0]     out_free_total,
  output logic                          out_error
);
  import gba_pkg::*;

  cmd_t    cmd;
  status_t sts;

  gba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  gba_dp #(
    .ENTRIES    (ENTRIES),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_block_index   (in_block_index),
    .out_result_index (out_result_index),
    .out_found        (out_found),
    .out_is_used      (out_is_used),
    .out_free_total   (out_free_total),
    .out_error        (out_error)
  );

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("transaction not taken up");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_is_used && !out_error))
    else $error("allocation result inconsistent");
`endif

endmodule

// ===== rtl/gba_ctrl.sv =====
// controller state machine sequencing clear, lookup, scan, group search and update
module gba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  gba_pkg::status_t sts,
  output gba_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import gba_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_GROUP = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_FETCH;
      S_FETCH: begin
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else if (sts.alloc) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.query || !sts.bit_set) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GROUP;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = S_GROUP;
        end else if (sts.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_GROUP: if (sts.group_done) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && start;
    cmd.clear  = (state_r == S_CLEAR);
    cmd.fetch  = (state_r == S_FETCH) && !sts.bad && !sts.alloc;
    cmd.check  = (state_r == S_CHECK);
    cmd.scan   = (state_r == S_SCAN);
    cmd.group  = (state_r == S_GROUP);
    cmd.write  = (state_r == S_WRITE);
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// ===== rtl/gba_dp.sv =====
// datapath: bitmap memory, scan logic, group search, counters and config registers
module gba_dp #(
  parameter int unsigned ENTRIES    = gba_pkg::DEF_ENTRIES,
  parameter int unsigned MAX_GROUPS = gba_pkg::DEF_MAX_GROUPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gba_pkg::cmd_t                 cmd,
  output gba_pkg::status_t              sts,
  input  logic                          cfg_we,
  input  logic [gba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gba_pkg::CFG_W-1:0]     cfg_data,
  input  logic [gba_pkg::REQ_W-1:0]     in_req_type,
  input  logic [gba_pkg::IDX_W-1:0]     in_block_index,
  output logic [gba_pkg::IDX_W-1:0]     out_result_index,
  output logic                          out_found,
  output logic                          out_is_used,
  output logic [gba_pkg::CNT_W-1:0]     out_free_total,
  output logic                          out_error
);
  import gba_pkg::*;

  localparam int unsigned WORDS   = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned GW      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned THR_W   = BLK_W + $clog2(MAX_GROUPS + 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;
  logic [WADDR_W-1:0] raddr;
  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  logic [CFG_W-1:0] total_entries_r, entries_per_group_r;
  logic [CNT_W-1:0] used_total_r;
  logic [CNT_W-1:0] group_used_r [MAX_GROUPS];

  logic [REQ_W-1:0]   req_r;
  logic [BLK_W-1:0]   blk_r;
  logic [BLK_W-1:0]   lim_r;
  logic               bad_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic               found_r, used_r, err_r;
  logic [WORD_W-1:0]  word_r;
  logic [WADDR_W-1:0] waddr_r;
  logic [WADDR_W-1:0] clr_addr_r;
  logic [WADDR_W-1:0] scan_addr_r, chk_addr_r;
  logic               pend_r, issued_all_r;
  logic [GW-1:0]      g_r;
  logic [THR_W-1:0]   thr_r;

  logic [BLK_W-1:0]   lim;
  logic               in_bad;
  logic [WADDR_W-1:0] blk_word, last_word;
  logic [WORD_W-1:0]  mask, free_bits;
  logic [BIT_W-1:0]   hit_bit;
  logic               sel_bit;
  logic               grp_adv;
  logic [BLK_W-1:0]   hit_blk;

  // limit of valid blocks and early classification of a request
  assign lim = (32'(total_entries_r) > ENTRIES) ? BLK_W'(ENTRIES) : total_entries_r;
  always_comb begin
    in_bad = 1'b0;
    case (in_req_type)
      REQ_ALLOC:           in_bad = 1'b0;
      REQ_FREE, REQ_QUERY: in_bad = ({1'b0, in_block_index} >= lim);
      default:             in_bad = 1'b1;
    endcase
  end

  assign blk_word  = WADDR_W'(blk_r >> BIT_W);
  assign last_word = WADDR_W'((lim_r - BLK_W'(1)) >> BIT_W);
  assign sel_bit   = rdata_r[blk_r[BIT_W-1:0]];

  always_comb begin
    mask = '1;
    if (chk_addr_r == last_word && lim_r[BIT_W-1:0] != '0) begin
      mask = (WORD_W'(1) << lim_r[BIT_W-1:0]) - WORD_W'(1);
    end
  end
  assign free_bits = ~rdata_r & mask;
  assign hit_bit   = first_one(free_bits);
  assign hit_blk   = BLK_W'({chk_addr_r, hit_bit});

  assign grp_adv = (entries_per_group_r != '0) && (g_r != GW'(MAX_GROUPS - 1))
                   && (THR_W'(blk_r) >= thr_r);

  always_comb begin
    sts.clear_done = (clr_addr_r == WADDR_W'(WORDS - 1));
    sts.bad        = bad_r;
    sts.alloc      = (req_r == REQ_ALLOC);
    sts.query      = (req_r == REQ_QUERY);
    sts.bit_set    = sel_bit;
    sts.hit        = pend_r && (free_bits != '0);
    sts.miss       = pend_r && (free_bits == '0) && (chk_addr_r == last_word);
    sts.group_done = !grp_adv;
  end

  // bitmap memory
  assign raddr     = cmd.fetch ? blk_word : scan_addr_r;
  assign mem_we    = cmd.clear || cmd.write;
  assign mem_waddr = cmd.clear ? clr_addr_r : waddr_r;
  assign mem_wdata = cmd.clear ? '0 : word_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[raddr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_entries_r     <= RST_TOTAL;
      entries_per_group_r <= RST_PER_GROUP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL:     total_entries_r     <= cfg_data;
        REG_PER_GROUP: entries_per_group_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // control registers of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      pend_r       <= 1'b0;
      issued_all_r <= 1'b0;
      scan_addr_r  <= '0;
      used_total_r <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        group_used_r[i] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + WADDR_W'(1);
      end
      if (cmd.accept) begin
        pend_r       <= 1'b0;
        issued_all_r <= 1'b0;
        scan_addr_r  <= '0;
      end else if (cmd.scan) begin
        if (!issued_all_r) begin
          pend_r      <= 1'b1;
          scan_addr_r <= scan_addr_r + WADDR_W'(1);
          if (scan_addr_r == last_word) begin
            issued_all_r <= 1'b1;
          end
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.write) begin
        if (req_r == REQ_ALLOC) begin
          if (used_total_r != CNT_MAX) used_total_r <= used_total_r + CNT_W'(1);
          if (group_used_r[g_r] != CNT_MAX) begin
            group_used_r[g_r] <= group_used_r[g_r] + CNT_W'(1);
          end
        end else begin
          if (used_total_r != '0) used_total_r <= used_total_r - CNT_W'(1);
          if (group_used_r[g_r] != '0) begin
            group_used_r[g_r] <= group_used_r[g_r] - CNT_W'(1);
          end
        end
      end
    end
  end

  // request payload registers
  always_ff @(posedge clk) begin
    if (cmd.scan && !issued_all_r) begin
      chk_addr_r <= scan_addr_r;
    end
    if (cmd.accept) begin
      req_r     <= in_req_type;
      blk_r     <= BLK_W'(in_block_index);
      lim_r     <= lim;
      bad_r     <= in_bad || (in_req_type == REQ_ALLOC && lim == '0);
      res_idx_r <= (in_req_type == REQ_ALLOC) ? '0 : in_block_index;
      found_r   <= 1'b0;
      used_r    <= 1'b0;
      err_r     <= in_bad;
      g_r       <= '0;
      thr_r     <= THR_W'(entries_per_group_r);
    end
    if (cmd.check) begin
      if (req_r == REQ_QUERY) begin
        used_r <= sel_bit;
      end else if (!sel_bit) begin
        err_r <= 1'b1;
      end
      word_r  <= rdata_r & ~(WORD_W'(1) << blk_r[BIT_W-1:0]);
      waddr_r <= blk_word;
    end
    if (cmd.scan && sts.hit) begin
      blk_r     <= hit_blk;
      res_idx_r <= IDX_W'(hit_blk);
      found_r   <= 1'b1;
      used_r    <= 1'b1;
      word_r    <= rdata_r | (WORD_W'(1) << hit_bit);
      waddr_r   <= chk_addr_r;
    end
    if (cmd.group && grp_adv) begin
      g_r   <= g_r + GW'(1);
      thr_r <= thr_r + THR_W'(entries_per_group_r);
    end
  end

  assign out_result_index = res_idx_r;
  assign out_found        = found_r;
  assign out_is_used      = used_r;
  assign out_error        = err_r;
  assign out_free_total   = (lim_r > used_total_r) ? (lim_r - used_total_r) : '0;

endmodule
